/* rtl/eti_frame_tist_extractor_unit_assert.svh */
// Assertion macros for the checker file of the ETI TIST extractor.
`ifndef ETI_FRAME_TIST_EXTRACTOR_UNIT_ASSERT_SVH
`define ETI_FRAME_TIST_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ETI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eti tist check failed");

// Next-cycle implication, disabled while reset is high.
`define ETI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eti tist check failed");

`endif

/* rtl/eti_tist_pkg.sv */
`timescale 1ns / 1ps

package eti_tist_pkg;

  // Frame length in bytes; the last byte position is FRAME_BYTES - 1.
  localparam int FRAME_BYTES = 6144;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIC   = 2'd1;
  localparam logic [1:0] STATUS_PAST_END = 2'd2;

  // One frame byte with its framing side band.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_start;
    logic [15:0] reference_count;
  } item_t;

  // One decoded timestamp report.
  typedef struct packed {
    logic [23:0] tist_ticks;
    logic [10:0] tist_ms;
    logic [7:0]  frame_count;
    logic [6:0]  stream_count;
    logic        count_mismatch;
    logic [1:0]  status;
  } result_t;

endpackage

/* rtl/eti_frame_tist_extractor_unit.sv */
`timescale 1ns / 1ps
// The result is registered: it appears in the cycle after the frame byte that completes it.
// Throughput: one frame byte per cycle; the only back pressure is a held result
// register, so a byte is taken whenever the result slot is empty or draining.
// Reset (synchronous, active high) clears the active flag, the byte position and the
// result valid; parsing then waits for a byte flagged as frame start.
module eti_frame_tist_extractor_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  eti_tist_pkg::item_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output eti_tist_pkg::result_t result
);

  localparam logic [12:0] FCT_POS   = 13'd4;
  localparam logic [12:0] NST_POS   = 13'd5;
  localparam logic [12:0] MODE_POS  = 13'd6;
  localparam logic [12:0] DESC_POS  = 13'd8;
  localparam logic [12:0] LAST_POS  = 13'(eti_tist_pkg::FRAME_BYTES - 1);
  localparam logic [21:0] FRAME_END = 22'(eti_tist_pkg::FRAME_BYTES);

  // Residue modulo 250 by folding: 256 is 6 modulo 250.
  function automatic logic [7:0] mod250(input logic [15:0] x);
    logic [10:0] s1;
    logic [8:0]  s2;
    s1 = 11'({x[15:8], 2'b00}) + 11'({x[15:8], 1'b0}) + 11'(x[7:0]);
    s2 = 9'({s1[10:8], 2'b00}) + 9'({s1[10:8], 1'b0}) + 9'(s1[7:0]);
    return (s2 >= 9'd250) ? 8'(s2 - 9'd250) : s2[7:0];
  endfunction

  // Parsing state.
  logic [12:0] pos, pos_next, pos_cur;
  logic        active, active_cur;
  logic [7:0]  ref_mod, ref_mod_cur;
  logic [7:0]  fct, fct_cur, fct_next;
  logic [6:0]  nst, nst_cur, nst_next;
  logic [1:0]  mode, mode_cur, mode_next;
  logic [1:0]  len_hi, len_hi_cur, len_hi_next;
  logic [20:0] sum, sum_cur, sum_next;
  logic [23:0] tist_shift, tist_shift_cur, tist_shift_next;

  logic [9:0]  hdr_end;
  logic [9:0]  tist_base;
  logic [21:0] tist_end;
  logic        in_desc;
  logic        past_hdr;
  logic        emit;
  logic [1:0]  status_sel;
  logic [9:0]  ms_q;
  logic        ms_round;
  logic [10:0] ms_val;
  logic        accept;
  logic [7:0]  b;

  assign b          = item.data_byte;
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // A frame start restarts parsing from a cleared state at byte 0.
  always_comb begin
    if (item.frame_start) begin
      pos_cur        = '0;
      active_cur     = 1'b1;
      ref_mod_cur    = mod250(item.reference_count);
      fct_cur        = '0;
      nst_cur        = '0;
      mode_cur       = '0;
      len_hi_cur     = '0;
      sum_cur        = '0;
      tist_shift_cur = '0;
    end else begin
      pos_cur        = pos;
      active_cur     = active;
      ref_mod_cur    = ref_mod;
      fct_cur        = fct;
      nst_cur        = nst;
      mode_cur       = mode;
      len_hi_cur     = len_hi;
      sum_cur        = sum;
      tist_shift_cur = tist_shift;
    end
  end

  // Header fields and stream descriptor accumulation.
  always_comb begin
    pos_next        = pos_cur + 13'd1;
    fct_next        = fct_cur;
    nst_next        = nst_cur;
    mode_next       = mode_cur;
    len_hi_next     = len_hi_cur;
    sum_next        = sum_cur;
    tist_shift_next = {tist_shift_cur[15:0], b};

    if (pos_cur == FCT_POS) begin
      fct_next = b;
    end
    if (pos_cur == NST_POS) begin
      nst_next = b[6:0];
    end
    if (pos_cur == MODE_POS) begin
      mode_next = b[4:3];
    end

    // The header end only matters from byte 7 on, after NST is settled.
    hdr_end = 10'd7 + {1'b0, nst_cur, 2'b00};
    in_desc = (pos_cur >= DESC_POS) && (pos_cur <= 13'(hdr_end));

    if (in_desc && pos_cur[1:0] == 2'd2) begin
      len_hi_next = b[1:0];
    end
    if (in_desc && pos_cur[1:0] == 2'd3) begin
      sum_next = sum_cur + 21'({len_hi_cur, b, 3'b000});
    end

    // Last TIST byte: header, descriptors, FIC, streams, EOF, then 4 TIST bytes.
    tist_base = 10'd19 + {1'b0, nst_cur, 2'b00} + ((mode_cur == 2'd3) ? 10'd128 : 10'd96);
    tist_end  = 22'(tist_base) + 22'(sum_next);
    past_hdr  = (pos_cur >= 13'(hdr_end));
  end

  // Result selection.
  always_comb begin
    emit       = 1'b0;
    status_sel = eti_tist_pkg::STATUS_OK;
    if (pos_cur == NST_POS && !b[7]) begin
      emit       = 1'b1;
      status_sel = eti_tist_pkg::STATUS_NO_FIC;
    end else if (pos_cur == 13'(hdr_end) && tist_end >= FRAME_END) begin
      emit       = 1'b1;
      status_sel = eti_tist_pkg::STATUS_PAST_END;
    end else if (past_hdr && 22'(pos_cur) == tist_end) begin
      emit       = 1'b1;
      status_sel = eti_tist_pkg::STATUS_OK;
    end else if (pos_cur >= LAST_POS) begin
      emit       = 1'b1;
      status_sel = eti_tist_pkg::STATUS_PAST_END;
    end
  end

  // Milliseconds: divide by 16384, round half to even.
  always_comb begin
    ms_q     = tist_shift_next[23:14];
    ms_round = (tist_shift_next[13:0] > 14'h2000) ||
               (tist_shift_next[13:0] == 14'h2000 && ms_q[0]);
    ms_val   = {1'b0, ms_q} + 11'(ms_round);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept && active_cur) begin
        active <= ~emit;
        pos    <= pos_next;
      end
      if (accept) begin
        result_valid <= active_cur & emit;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && active_cur) begin
      ref_mod    <= ref_mod_cur;
      fct        <= fct_next;
      nst        <= nst_next;
      mode       <= mode_next;
      len_hi     <= len_hi_next;
      sum        <= sum_next;
      tist_shift <= tist_shift_next;
      if (emit) begin
        result.status         <= status_sel;
        result.frame_count    <= fct_next;
        result.stream_count   <= nst_next;
        result.count_mismatch <= (ref_mod_cur != fct_next);
        if (status_sel == eti_tist_pkg::STATUS_OK) begin
          result.tist_ticks <= tist_shift_next;
          result.tist_ms    <= ms_val;
        end else begin
          result.tist_ticks <= '0;
          result.tist_ms    <= '0;
        end
      end
    end
  end

endmodule

/* rtl/eti_tist_checker.sv */
`timescale 1ns / 1ps
`include "eti_frame_tist_extractor_unit_assert.svh"

module eti_tist_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input eti_tist_pkg::result_t result
);

  // A held result stays put until it is taken.
  `ETI_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // Requests are only held off by a waiting result.
  `ETI_ASSERT_NOW(a_stall_cause, item_stall, result_valid)

  // Error reports carry no timestamp.
  `ETI_ASSERT_NOW(a_error_zero,
    result_valid && result.status != eti_tist_pkg::STATUS_OK,
    result.tist_ticks == 24'd0 && result.tist_ms == 11'd0 &&
    (result.status == eti_tist_pkg::STATUS_NO_FIC ||
     result.status == eti_tist_pkg::STATUS_PAST_END))

  // Rounded milliseconds stay within one of the truncated value.
  `ETI_ASSERT_NOW(a_ms_range,
    result_valid && result.status == eti_tist_pkg::STATUS_OK,
    ((result.tist_ms == {1'b0, result.tist_ticks[23:14]}) ||
     (result.tist_ms == {1'b0, result.tist_ticks[23:14]} + 11'd1)))

endmodule

bind eti_frame_tist_extractor_unit eti_tist_checker u_eti_tist_checker (.*);
